// ===== design/fraction_reduce_min_select_defines.svh =====
// Assertion helpers for the fraction reduction block.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef FRACTION_REDUCE_MIN_SELECT_DEFINES_SVH
`define FRACTION_REDUCE_MIN_SELECT_DEFINES_SVH

`define FRMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fraction_reduce_min_select: same-cycle check failed");

`define FRMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fraction_reduce_min_select: next-cycle check failed");

`endif

// ===== design/frms_pkg.sv =====
`default_nettype none

package frms_pkg;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LANE  = 4'b0010,
    S_MERGE = 4'b0100,
    S_PUT   = 4'b1000
  } top_state_e;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_GCD  = 4'b0010,
    L_DIV  = 4'b0100,
    L_DONE = 4'b1000
  } lane_state_e;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_MUL  = 3'b010,
    M_DONE = 3'b100
  } merge_state_e;

endpackage

`default_nettype wire

// ===== design/frms_in_if.sv =====
`default_nettype none

interface frms_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] num_a;
  logic        [VALUE_WIDTH-2:0] den_a;
  logic signed [VALUE_WIDTH-1:0] num_b;
  logic        [VALUE_WIDTH-2:0] den_b;

  modport source (output valid, output num_a, output den_a, output num_b, output den_b,
                  input ready);
  modport sink   (input valid, input num_a, input den_a, input num_b, input den_b,
                  output ready);
endinterface

`default_nettype wire

// ===== design/frms_out_if.sv =====
`default_nettype none

interface frms_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] min_num;
  logic        [VALUE_WIDTH-2:0] min_den;
  logic                          zero_den_error;

  modport source (output valid, output min_num, output min_den, output zero_den_error,
                  input ready);
  modport sink   (input valid, input min_num, input min_den, input zero_den_error,
                  output ready);
endinterface

`default_nettype wire

// ===== design/frms_lane.sv =====
`default_nettype none

module frms_lane #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] num_i,
  input  logic [VALUE_WIDTH-2:0] den_i,
  output logic                   done_o,
  output logic                   neg_o,
  output logic [VALUE_WIDTH-1:0] mag_o,
  output logic [VALUE_WIDTH-2:0] den_o
);

  localparam int unsigned NW = VALUE_WIDTH;
  localparam int unsigned DW = NW - 1;
  localparam int unsigned KW = $clog2(NW + 1);

  // One restoring division step: returns the new remainder and the quotient bit.
  function automatic logic [NW:0] div_step(logic [NW-1:0] rem, logic msb,
                                           logic [NW-1:0] dvs);
    logic [NW:0] shifted;
    logic [NW:0] diff;
    shifted = {rem, msb};
    diff    = shifted - {1'b0, dvs};
    if (shifted >= {1'b0, dvs}) begin
      div_step = {diff[NW-1:0], 1'b1};
    end else begin
      div_step = {shifted[NW-1:0], 1'b0};
    end
  endfunction

  frms_pkg::lane_state_e state_q, state_d;
  logic          neg_q, neg_d;
  logic [NW-1:0] mag_q, mag_d;
  logic [NW-1:0] den_q, den_d;
  logic [NW-1:0] a_q, a_d;
  logic [NW-1:0] b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [NW-1:0] g_q, g_d;
  logic [NW-1:0] rm_q, rm_d;
  logic [NW-1:0] rd_q, rd_d;
  logic [KW-1:0] cnt_q, cnt_d;

  logic [NW-1:0] num_mag;
  logic [NW:0]   qm_step;
  logic [NW:0]   qd_step;
  logic          gcd_found;

  assign num_mag = num_i[NW-1] ? ('0 - num_i) : num_i;
  assign qm_step = div_step(rm_q, mag_q[NW-1], g_q);
  assign qd_step = div_step(rd_q, den_q[NW-1], g_q);

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    den_d     = den_q;
    a_d       = a_q;
    b_d       = b_q;
    k_d       = k_q;
    g_d       = g_q;
    rm_d      = rm_q;
    rd_d      = rd_q;
    cnt_d     = cnt_q;
    gcd_found = 1'b0;
    case (state_q)
      frms_pkg::L_IDLE, frms_pkg::L_DONE: begin
        if (start_i) begin
          neg_d   = num_i[NW-1];
          mag_d   = num_mag;
          den_d   = {1'b0, den_i};
          a_d     = num_mag;
          b_d     = {1'b0, den_i};
          k_d     = '0;
          state_d = frms_pkg::L_GCD;
        end
      end
      frms_pkg::L_GCD: begin
        if (a_q == '0) begin
          g_d       = b_q << k_q;
          gcd_found = 1'b1;
        end else if (b_q == '0) begin
          g_d       = a_q << k_q;
          gcd_found = 1'b1;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
        if (gcd_found) begin
          rm_d    = '0;
          rd_d    = '0;
          cnt_d   = KW'(NW);
          state_d = frms_pkg::L_DIV;
        end
      end
      frms_pkg::L_DIV: begin
        mag_d = {mag_q[NW-2:0], qm_step[0]};
        rm_d  = qm_step[NW:1];
        den_d = {den_q[NW-2:0], qd_step[0]};
        rd_d  = qd_step[NW:1];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == KW'(1)) begin
          state_d = frms_pkg::L_DONE;
        end
      end
      default: begin
        state_d = frms_pkg::L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frms_pkg::L_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    den_q <= den_d;
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    g_q   <= g_d;
    rm_q  <= rm_d;
    rd_q  <= rd_d;
    cnt_q <= cnt_d;
  end

  assign done_o = (state_q == frms_pkg::L_DONE);
  assign neg_o  = neg_q & (|mag_q);
  assign mag_o  = mag_q;
  assign den_o  = den_q[DW-1:0];

endmodule

`default_nettype wire

// ===== design/frms_merge.sv =====
`default_nettype none

module frms_merge #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   neg_a_i,
  input  logic [VALUE_WIDTH-1:0] mag_a_i,
  input  logic [VALUE_WIDTH-2:0] den_a_i,
  input  logic                   neg_b_i,
  input  logic [VALUE_WIDTH-1:0] mag_b_i,
  input  logic [VALUE_WIDTH-2:0] den_b_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] min_num_o,
  output logic [VALUE_WIDTH-2:0] min_den_o
);

  localparam int unsigned NW = VALUE_WIDTH;
  localparam int unsigned DW = NW - 1;
  localparam int unsigned PW = NW + DW;
  localparam int unsigned CW = $clog2(DW + 1);

  // One shift-add step; the multiplier sits in the low bits and shifts out.
  function automatic logic [PW-1:0] mul_step(logic [PW-1:0] p, logic [NW-1:0] m);
    logic [NW:0] sum;
    sum      = {1'b0, p[PW-1:DW]} + (p[0] ? {1'b0, m} : '0);
    mul_step = {sum, p[DW-1:1]};
  endfunction

  frms_pkg::merge_state_e state_q, state_d;
  logic          neg_a_q, neg_a_d, neg_b_q, neg_b_d;
  logic [NW-1:0] mag_a_q, mag_a_d, mag_b_q, mag_b_d;
  logic [DW-1:0] den_a_q, den_a_d, den_b_q, den_b_d;
  logic [PW-1:0] p1_q, p1_d, p2_q, p2_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic          pick_a;
  logic          sel_neg;
  logic [NW-1:0] sel_mag;

  always_comb begin
    state_d = state_q;
    neg_a_d = neg_a_q;
    neg_b_d = neg_b_q;
    mag_a_d = mag_a_q;
    mag_b_d = mag_b_q;
    den_a_d = den_a_q;
    den_b_d = den_b_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    cnt_d   = cnt_q;
    case (state_q)
      frms_pkg::M_IDLE, frms_pkg::M_DONE: begin
        if (start_i) begin
          neg_a_d = neg_a_i;
          neg_b_d = neg_b_i;
          mag_a_d = mag_a_i;
          mag_b_d = mag_b_i;
          den_a_d = den_a_i;
          den_b_d = den_b_i;
          p1_d    = PW'(den_b_i);
          p2_d    = PW'(den_a_i);
          cnt_d   = CW'(DW);
          state_d = frms_pkg::M_MUL;
        end
      end
      frms_pkg::M_MUL: begin
        p1_d  = mul_step(p1_q, mag_a_q);
        p2_d  = mul_step(p2_q, mag_b_q);
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = frms_pkg::M_DONE;
        end
      end
      default: begin
        state_d = frms_pkg::M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frms_pkg::M_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_a_q <= neg_a_d;
    neg_b_q <= neg_b_d;
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
    den_a_q <= den_a_d;
    den_b_q <= den_b_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    cnt_q   <= cnt_d;
  end

  // For two negative fractions the larger magnitude is the smaller value.
  always_comb begin
    if (neg_a_q != neg_b_q) begin
      pick_a = neg_a_q;
    end else if (neg_a_q) begin
      pick_a = (p2_q <= p1_q);
    end else begin
      pick_a = (p1_q <= p2_q);
    end
  end

  assign sel_neg   = pick_a ? neg_a_q : neg_b_q;
  assign sel_mag   = pick_a ? mag_a_q : mag_b_q;
  assign min_num_o = sel_neg ? ('0 - sel_mag) : sel_mag;
  assign min_den_o = pick_a ? den_a_q : den_b_q;
  assign done_o    = (state_q == frms_pkg::M_DONE);

endmodule

`default_nettype wire

// ===== design/fraction_reduce_min_select.sv =====
// A transaction runs a data-dependent binary GCD in each lane, then division by the GCD,
// then a shift-add cross-product in the merge; a zero denominator skips to the output.
// One transaction is in flight; the next is taken once the result sits in the output register.
// Reset is asynchronous and active low; it clears the control state only.
`default_nettype none
`include "fraction_reduce_min_select_defines.svh"

module fraction_reduce_min_select #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  frms_in_if.sink    in_i,
  frms_out_if.source out_o
);

  localparam int unsigned NW = VALUE_WIDTH;
  localparam int unsigned DW = NW - 1;

  frms_pkg::top_state_e state_q, state_d;
  logic          err_q, err_d;
  logic          out_valid_q, out_valid_d;
  logic [NW-1:0] out_num_q;
  logic [DW-1:0] out_den_q;
  logic          out_err_q;

  logic          in_fire;
  logic          den_zero;
  logic          lane_start;
  logic          merge_start;
  logic          out_load;

  logic          lane_done_a, lane_done_b;
  logic          lane_neg_a, lane_neg_b;
  logic [NW-1:0] lane_mag_a, lane_mag_b;
  logic [DW-1:0] lane_den_a, lane_den_b;
  logic          merge_done;
  logic [NW-1:0] merge_num;
  logic [DW-1:0] merge_den;

  assign in_i.ready = (state_q == frms_pkg::S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign den_zero   = (in_i.den_a == '0) || (in_i.den_b == '0);
  assign lane_start = in_fire && !den_zero;

  frms_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lane_start),
    .num_i  (in_i.num_a),
    .den_i  (in_i.den_a),
    .done_o (lane_done_a),
    .neg_o  (lane_neg_a),
    .mag_o  (lane_mag_a),
    .den_o  (lane_den_a)
  );

  frms_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lane_start),
    .num_i  (in_i.num_b),
    .den_i  (in_i.den_b),
    .done_o (lane_done_b),
    .neg_o  (lane_neg_b),
    .mag_o  (lane_mag_b),
    .den_o  (lane_den_b)
  );

  frms_merge #(.VALUE_WIDTH(VALUE_WIDTH)) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (merge_start),
    .neg_a_i  (lane_neg_a),
    .mag_a_i  (lane_mag_a),
    .den_a_i  (lane_den_a),
    .neg_b_i  (lane_neg_b),
    .mag_b_i  (lane_mag_b),
    .den_b_i  (lane_den_b),
    .done_o   (merge_done),
    .min_num_o(merge_num),
    .min_den_o(merge_den)
  );

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    merge_start = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      frms_pkg::S_IDLE: begin
        if (in_fire) begin
          err_d   = den_zero;
          state_d = den_zero ? frms_pkg::S_PUT : frms_pkg::S_LANE;
        end
      end
      frms_pkg::S_LANE: begin
        if (lane_done_a && lane_done_b) begin
          merge_start = 1'b1;
          state_d     = frms_pkg::S_MERGE;
        end
      end
      frms_pkg::S_MERGE: begin
        if (merge_done) begin
          state_d = frms_pkg::S_PUT;
        end
      end
      frms_pkg::S_PUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = frms_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = frms_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frms_pkg::S_IDLE;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_num_q <= err_q ? '0 : merge_num;
      out_den_q <= err_q ? '0 : merge_den;
      out_err_q <= err_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.min_num        = out_num_q;
  assign out_o.min_den        = out_den_q;
  assign out_o.zero_den_error = out_err_q;

  `FRMS_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_q != frms_pkg::S_IDLE)
  `FRMS_ASSERT_NEXT(a_merge_start_clears_done, merge_start, !merge_done)
  `FRMS_ASSERT_IMPL(a_error_fields_zero, out_valid_q && out_err_q, out_num_q == '0 && out_den_q == '0)
  `FRMS_ASSERT_NEXT(a_load_sets_valid, out_load, out_o.valid)

endmodule

`default_nettype wire

// ===== dv/tb_fraction_reduce_min_select.sv =====
`timescale 1ns / 100ps

module tb_fraction_reduce_min_select;

  localparam int W = 32;
  localparam logic signed [W-1:0] NUM_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] NUM_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-2:0] DEN_MAX = '1;
  localparam int RANDOM_PAIRS = 1810;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [W-1:0] num_a;
    logic [W-2:0] den_a;
    logic signed [W-1:0] num_b;
    logic [W-2:0] den_b;
  } frac_pair_t;

  typedef struct packed {
    logic signed [W-1:0] num;
    logic [W-2:0] den;
    logic err;
  } min_frac_t;

  typedef struct packed {
    bit neg;
    logic [63:0] mag;
    logic [63:0] den;
  } lowest_terms_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  frms_in_if #(.VALUE_WIDTH(W)) pair_if ();
  frms_out_if #(.VALUE_WIDTH(W)) min_if ();

  fraction_reduce_min_select #(.VALUE_WIDTH(W)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pair_if),
    .out_o (min_if)
  );

  min_frac_t expected_mins[$];
  int fail_count = 0;
  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  int hold_off_cycles = 0;

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (x != 0) begin
      r = y % x;
      y = x;
      x = r;
    end
    return y;
  endfunction

  function automatic lowest_terms_t to_lowest_terms(logic signed [W-1:0] num, logic [W-2:0] den);
    lowest_terms_t t;
    longint sn;
    longint unsigned g;
    sn = num;
    t.neg = (sn < 0);
    t.mag = t.neg ? -sn : sn;
    g = euclid_gcd(t.mag, 64'(den));
    t.mag = t.mag / g;
    t.den = 64'(den) / g;
    if (t.mag == 0) begin
      t.neg = 1'b0;
    end
    return t;
  endfunction

  function automatic min_frac_t predict_min_fraction(frac_pair_t p);
    min_frac_t res;
    lowest_terms_t a;
    lowest_terms_t b;
    lowest_terms_t w;
    bit a_le_b;
    longint sv;
    res = '0;
    if (p.den_a == 0 || p.den_b == 0) begin
      res.err = 1'b1;
      return res;
    end
    a = to_lowest_terms(p.num_a, p.den_a);
    b = to_lowest_terms(p.num_b, p.den_b);
    if (a.neg != b.neg) begin
      a_le_b = a.neg;
    end else if (!a.neg) begin
      a_le_b = (a.mag * b.den) <= (b.mag * a.den);
    end else begin
      a_le_b = (b.mag * a.den) <= (a.mag * b.den);
    end
    w = a_le_b ? a : b;
    sv = w.neg ? -longint'(w.mag) : longint'(w.mag);
    res.num = sv[W-1:0];
    res.den = w.den[W-2:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pair_if.valid && pair_if.ready) begin
      expected_mins.push_back(predict_min_fraction(
          {pair_if.num_a, pair_if.den_a, pair_if.num_b, pair_if.den_b}));
    end
  end

  always @(posedge clk_i) begin : check_results
    min_frac_t want;
    if (rst_ni && min_if.valid && min_if.ready) begin
      if (expected_mins.size() == 0) begin
        $error("Result transaction with no input pending: min_num %0d, min_den %0d",
               min_if.min_num, min_if.min_den);
        fail_count++;
      end else begin
        want = expected_mins.pop_front();
        if (min_if.min_num !== want.num) begin
          $error("min_num: expected %0d, got %0d", want.num, min_if.min_num);
          fail_count++;
        end
        if (min_if.min_den !== want.den) begin
          $error("min_den: expected %0d, got %0d", want.den, min_if.min_den);
          fail_count++;
        end
        if (min_if.zero_den_error !== want.err) begin
          $error("zero_den_error: expected %0d, got %0d", want.err, min_if.zero_den_error);
          fail_count++;
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    min_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      stall = sink_stalls_on ? $urandom_range(0, 12) : 0;
      @(negedge clk_i);
      if (stall > 0 || hold_off_cycles > 0) begin
        min_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
        while (hold_off_cycles > 0) begin
          hold_off_cycles--;
          @(negedge clk_i);
        end
      end
      min_if.ready <= 1'b1;
      do @(posedge clk_i); while (!min_if.valid);
    end
  end

  task automatic offer_pair(input logic signed [W-1:0] num_a, input logic [W-2:0] den_a,
                            input logic signed [W-1:0] num_b, input logic [W-2:0] den_b);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 12) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      pair_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pair_if.valid <= 1'b1;
    pair_if.num_a <= num_a;
    pair_if.den_a <= den_a;
    pair_if.num_b <= num_b;
    pair_if.den_b <= den_b;
    do @(posedge clk_i); while (!pair_if.ready);
  endtask

  function automatic logic signed [W-1:0] edge_num();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 1;
      2: return -1;
      3: return NUM_MAX;
      4: return -NUM_MAX;
      5: return NUM_MIN;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [W-2:0] edge_den();
    case ($urandom_range(0, 3))
      0: return 1;
      1: return DEN_MAX;
      2: return (W-1)'(DEN_MAX - 1);
      default: return (W-1)'($urandom_range(1, 32'h7FFF_FFFF));
    endcase
  endfunction

  function automatic frac_pair_t random_pair();
    frac_pair_t p;
    int pick;
    int f;
    int n;
    int d;
    int k1;
    int k2;
    pick = $urandom_range(0, 99);
    p.num_a = $urandom();
    p.den_a = (W-1)'($urandom());
    p.num_b = $urandom();
    p.den_b = (W-1)'($urandom());
    if (pick >= 35 && pick < 65) begin
      f = $urandom_range(1, 1000);
      p.num_a = (int'($urandom_range(0, 2000)) - 1000) * f;
      p.den_a = (W-1)'($urandom_range(1, 1000) * f);
      f = $urandom_range(1, 1000);
      p.num_b = (int'($urandom_range(0, 2000)) - 1000) * f;
      p.den_b = (W-1)'($urandom_range(1, 1000) * f);
    end else if (pick >= 65 && pick < 82) begin
      n = int'($urandom_range(0, 200)) - 100;
      d = $urandom_range(1, 100);
      k1 = $urandom_range(1, 5000);
      k2 = $urandom_range(1, 5000);
      p.num_a = n * k1;
      p.den_a = (W-1)'(d * k1);
      p.num_b = (n + int'($urandom_range(0, 2)) - 1) * k2;
      p.den_b = (W-1)'(d * k2);
    end else if (pick >= 82 && pick < 94) begin
      p.num_a = edge_num();
      p.den_a = edge_den();
      p.num_b = edge_num();
      p.den_b = edge_den();
    end else if (pick >= 94) begin
      case ($urandom_range(0, 2))
        0: p.den_a = '0;
        1: p.den_b = '0;
        default: begin
          p.den_a = '0;
          p.den_b = '0;
        end
      endcase
    end
    return p;
  endfunction

  task automatic test_extremes();
    offer_pair(NUM_MAX, DEN_MAX, -NUM_MAX, DEN_MAX);
    offer_pair(NUM_MIN, 3, NUM_MIN, 1);
    offer_pair(NUM_MIN, 1024, 5, 1);
    offer_pair(NUM_MAX, 1, NUM_MAX, DEN_MAX);
    offer_pair(NUM_MAX, (W-1)'(DEN_MAX - 1), NUM_MAX - 1, (W-1)'(DEN_MAX - 2));
    offer_pair(0, DEN_MAX, 0, 1);
    offer_pair(-1, DEN_MAX, 0, 5);
    offer_pair(32'sh5555_5555, 31'h2AAA_AAAA, 32'shAAAA_AAAA, 31'h5555_5555);
  endtask

  task automatic test_zero_denominator();
    offer_pair(7, 0, 3, 4);
    offer_pair(3, 4, -7, 0);
    offer_pair(NUM_MIN, 0, 0, 0);
  endtask

  task automatic test_ties_and_signs();
    offer_pair(6, 4, 3, 2);
    offer_pair(-6, 4, -9, 6);
    offer_pair(4, 6, -4, 6);
    offer_pair(-4, 6, 4, 6);
    offer_pair(-3, 7, -2, 7);
    offer_pair(2, 7, 3, 7);
    offer_pair(12, 18, 1000, 1500);
    offer_pair(NUM_MIN, 2, -NUM_MAX, 1);
  endtask

  task automatic test_backpressure();
    frac_pair_t p;
    src_gaps_on = 1'b0;
    hold_off_cycles = 400;
    for (int i = 0; i < 20; i++) begin
      p = random_pair();
      offer_pair(p.num_a, p.den_a, p.num_b, p.den_b);
    end
    src_gaps_on = 1'b1;
  endtask

  task automatic test_random(input int count);
    frac_pair_t p;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        src_gaps_on = (i != 0) && ($urandom_range(0, 3) != 0);
        sink_stalls_on = (i != 0) && ($urandom_range(0, 3) != 0);
      end
      p = random_pair();
      offer_pair(p.num_a, p.den_a, p.num_b, p.den_b);
    end
  endtask

  initial begin
    pair_if.valid = 1'b0;
    pair_if.num_a = '0;
    pair_if.den_a = '0;
    pair_if.num_b = '0;
    pair_if.den_b = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_zero_denominator();
    test_ties_and_signs();
    test_backpressure();
    test_random(RANDOM_PAIRS);

    @(negedge clk_i);
    pair_if.valid <= 1'b0;
    while (expected_mins.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
